// ===== src/utf8_lenient_decoder_macros.svh =====
// Assertion helpers shared by the decoder modules.
`ifndef UTF8_LENIENT_DECODER_MACROS_SVH
`define UTF8_LENIENT_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8LD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTF8LD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/utf8ld_pkg.sv =====
`default_nettype none

package utf8ld_pkg;

    localparam int unsigned CP_W        = 21;
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [CP_W-1:0] FALLBACK_CP = 21'd63;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       text_last;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            substituted;
        logic            run_last;
        logic            text_end;
    } out_item_t;

    // Results produced by one byte; items[0] is delivered first.
    typedef struct packed {
        logic [1:0]                       count;
        out_item_t [MAX_RESULTS-1:0]      items;
    } dec_res_t;

endpackage

`default_nettype wire

// ===== src/utf8ld_decode.sv =====
`default_nettype none

`include "utf8_lenient_decoder_macros.svh"

module utf8ld_decode (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire utf8ld_pkg::in_item_t item,
    output utf8ld_pkg::dec_res_t      res
);
    import utf8ld_pkg::*;

    logic [7:0] held_reg [0:2];
    logic [1:0] held_count_reg, held_count_next;
    logic [1:0] need_reg, need_next;
    logic       held_wr;

    function automatic logic [1:0] lead_need(input logic [7:0] b);
        logic [1:0] k;
        k = 2'd0;
        if ((b & 8'hE0) == 8'hC0) begin
            k = 2'd1;
        end else if ((b & 8'hF0) == 8'hE0) begin
            k = 2'd2;
        end else if ((b & 8'hF8) == 8'hF0) begin
            k = 2'd3;
        end
        return k;
    endfunction

    // Builds a code point from a lead, up to two middle bytes and the final byte.
    function automatic logic [CP_W-1:0] assemble(input logic [1:0] k, input logic [7:0] lead,
                                                 input logic [7:0] h1, input logic [7:0] h2,
                                                 input logic [7:0] b);
        logic [CP_W-1:0] cp;
        case (k)
            2'd2:    cp = {5'd0, lead[3:0], h1[5:0], b[5:0]};
            2'd3:    cp = {lead[2:0], h1[5:0], h2[5:0], b[5:0]};
            default: cp = {10'd0, lead[4:0], b[5:0]};
        endcase
        return cp;
    endfunction

    function automatic out_item_t mk(input logic [CP_W-1:0] cp, input logic sub);
        out_item_t r;
        r.code_point  = cp;
        r.substituted = sub;
        r.run_last    = 1'b0;
        r.text_end    = 1'b0;
        return r;
    endfunction

    // A lone byte at the very end of the text.
    function automatic out_item_t single(input logic [7:0] b);
        out_item_t r;
        if (b < 8'h80) begin
            r = mk({13'd0, b}, 1'b0);
        end else begin
            r = mk(FALLBACK_CP, 1'b1);
        end
        return r;
    endfunction

    always_comb begin
        logic [7:0] b;
        logic [7:0] t0;
        b               = item.data_byte;
        t0              = held_reg[1];
        res             = '0;
        held_count_next = held_count_reg;
        need_next       = need_reg;
        held_wr         = 1'b0;

        if (item.text_last) begin
            held_count_next = 2'd0;
            need_next       = 2'd0;
            if (held_count_reg == 2'd0) begin
                res.items[0] = single(b);
                res.count    = 2'd1;
            end else if (held_count_reg >= need_reg) begin
                res.items[0] = mk(assemble(need_reg, held_reg[0], held_reg[1], held_reg[2], b),
                                  1'b0);
                res.count    = 2'd1;
            end else begin
                // Truncated sequence: the lead falls back and the rest is decoded again.
                res.items[0] = mk(FALLBACK_CP, 1'b1);
                if (held_count_reg == 2'd1) begin
                    res.items[1] = single(b);
                    res.count    = 2'd2;
                end else if (t0 < 8'h80) begin
                    res.items[1] = mk({13'd0, t0}, 1'b0);
                    res.items[2] = single(b);
                    res.count    = 2'd3;
                end else if (lead_need(t0) == 2'd1) begin
                    res.items[1] = mk(assemble(2'd1, t0, 8'd0, 8'd0, b), 1'b0);
                    res.count    = 2'd2;
                end else begin
                    res.items[1] = mk(FALLBACK_CP, 1'b1);
                    res.items[2] = single(b);
                    res.count    = 2'd3;
                end
            end
        end else if (held_count_reg == 2'd0) begin
            if (b < 8'h80) begin
                res.items[0] = mk({13'd0, b}, 1'b0);
                res.count    = 2'd1;
            end else if (lead_need(b) != 2'd0) begin
                held_wr         = 1'b1;
                held_count_next = 2'd1;
                need_next       = lead_need(b);
            end else begin
                res.items[0] = mk(FALLBACK_CP, 1'b1);
                res.count    = 2'd1;
            end
        end else if (held_count_reg >= need_reg) begin
            res.items[0]    = mk(assemble(need_reg, held_reg[0], held_reg[1], held_reg[2], b),
                                 1'b0);
            res.count       = 2'd1;
            held_count_next = 2'd0;
            need_next       = 2'd0;
        end else begin
            held_wr         = 1'b1;
            held_count_next = held_count_reg + 2'd1;
        end

        if (res.count != 2'd0) begin
            res.items[res.count - 2'd1].run_last = 1'b1;
            res.items[res.count - 2'd1].text_end = item.text_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= 2'd0;
            need_reg       <= 2'd0;
        end else if (en) begin
            held_count_reg <= held_count_next;
            need_reg       <= need_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && held_wr) begin
            held_reg[held_count_reg] <= item.data_byte;
        end
    end

    `UTF8LD_ASSERT_NOW(a_count_le_need, aclk, aresetn, 1'b1, held_count_reg <= need_reg)
    `UTF8LD_ASSERT_NOW(a_idle_pair, aclk, aresetn, 1'b1,
                       (held_count_reg == 2'd0) == (need_reg == 2'd0))
    `UTF8LD_ASSERT_NEXT(a_last_clears, aclk, aresetn, en && item.text_last,
                        held_count_reg == 2'd0)

endmodule

`default_nettype wire

// ===== src/utf8ld_out_buf.sv =====
`default_nettype none

`include "utf8_lenient_decoder_macros.svh"

module utf8ld_out_buf (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire utf8ld_pkg::dec_res_t res,
    output logic                      load_ok,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output utf8ld_pkg::out_item_t     m_item
);
    import utf8ld_pkg::*;

    out_item_t  slot_reg [0:MAX_RESULTS-1];
    logic [1:0] rem_reg, rem_next;
    logic       m_xfer;

    assign m_valid = (rem_reg != 2'd0);
    assign m_item  = slot_reg[0];
    assign m_xfer  = m_valid && m_ready;
    assign load_ok = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && m_ready);

    always_comb begin
        rem_next = rem_reg;
        if (load) begin
            rem_next = res.count;
        end else if (m_xfer) begin
            rem_next = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg[0] <= res.items[0];
            slot_reg[1] <= res.items[1];
            slot_reg[2] <= res.items[2];
        end else if (m_xfer) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    `UTF8LD_ASSERT_NEXT(a_load_shows, aclk, aresetn, load && (res.count != 2'd0), m_valid)
    `UTF8LD_ASSERT_NOW(a_run_last_pos, aclk, aresetn, m_valid,
                       m_item.run_last == (rem_reg == 2'd1))

endmodule

`default_nettype wire

// ===== src/utf8_lenient_decoder.sv =====
// A byte first waits in the input register and is then loaded into the output buffer,
// which offers its first result; the load waits until the buffer can take it.
// Throughput: one byte per cycle while the buffer is free; a byte that ends the text
// inside a sequence can give up to three results; new bytes wait while these drain.
// Reset: aresetn is synchronous and active low; it empties both stages and drops any
// partly collected sequence. The held byte store itself is not cleared.
`default_nettype none

module utf8_lenient_decoder (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire utf8ld_pkg::in_item_t  s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output utf8ld_pkg::out_item_t      m_item
);
    import utf8ld_pkg::*;

    // Input register: one accepted byte waits here until the output buffer can take
    // everything that it produces.
    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;

    logic     load_ok;
    logic     advance;
    logic     s_xfer;
    dec_res_t dec_res;

    // A byte moves on when the output buffer is empty, or is about to hand over its
    // last result in this cycle. The input register is then free for the next transfer.
    assign advance = in_valid_reg && load_ok;
    assign s_ready = !in_valid_reg || load_ok;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg <= s_item;
        end
    end

    // The decoder holds the partial sequence and works out the results of the byte in
    // the input register; its state only moves when the byte moves on.
    utf8ld_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (in_item_reg),
        .res     (dec_res)
    );

    // The output buffer keeps up to three results and offers them one transfer at a time.
    utf8ld_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .res     (dec_res),
        .load_ok (load_ok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire

// ===== tb/sv/utf8_decode_checker.sv =====
`default_nettype none

module utf8_decode_checker (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire utf8ld_pkg::in_item_t  s_item,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire utf8ld_pkg::out_item_t m_item,
    output int unsigned                mismatches,
    output int unsigned                results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import utf8ld_pkg::*;

    // Code points still to come out of the block, oldest first.
    out_item_t   code_points_due[$];

    // Own copy of the partly collected sequence.
    logic [7:0]  held [0:2];
    logic [1:0]  held_cnt;
    logic [1:0]  need_cnt;

    int unsigned fail_count = 0;

    assign mismatches = fail_count;

    function automatic logic [1:0] follower_need(input logic [7:0] b);
        if (b[7:5] == 3'b110) return 2'd1;
        if (b[7:4] == 4'b1110) return 2'd2;
        if (b[7:3] == 5'b11110) return 2'd3;
        return 2'd0;
    endfunction

    // Joins a lead at position first with the k bytes after it.
    function automatic logic [CP_W-1:0] join_code(input logic [3:0][7:0] seq,
                                                  input int unsigned first,
                                                  input int unsigned k);
        logic [CP_W-1:0] cp;
        case (k)
            1: begin
                cp = {16'd0, seq[first][4:0]};
            end
            2: begin
                cp = {17'd0, seq[first][3:0]};
            end
            default: begin
                cp = {18'd0, seq[first][2:0]};
            end
        endcase
        for (int unsigned i = 1; i <= k; i++)
            cp = {cp[CP_W-7:0], seq[first+i][5:0]};
        return cp;
    endfunction

    function automatic out_item_t make_result(input logic [CP_W-1:0] cp, input logic sub);
        out_item_t r;
        r.code_point  = cp;
        r.substituted = sub;
        r.run_last    = 1'b0;
        r.text_end    = 1'b0;
        return r;
    endfunction

    task automatic decode_byte(input in_item_t it);
        logic [3:0][7:0] seq;
        out_item_t       fresh [0:3];
        int unsigned     n;
        int unsigned     len;
        int unsigned     pos;
        int unsigned     k;
        n   = 0;
        seq = '0;
        if (it.text_last) begin
            // The held bytes and this one are decoded as a text that stops here.
            len = 0;
            for (int unsigned i = 0; i < held_cnt; i++) begin
                seq[len] = held[i];
                len++;
            end
            seq[len] = it.data_byte;
            len++;
            pos = 0;
            while (pos < len) begin
                k = 32'(follower_need(seq[pos]));
                if (!seq[pos][7]) begin
                    fresh[n] = make_result({13'd0, seq[pos]}, 1'b0);
                    pos++;
                end else if (k != 0 && pos + k < len) begin
                    fresh[n] = make_result(join_code(seq, pos, k), 1'b0);
                    pos += k + 1;
                end else begin
                    fresh[n] = make_result(FALLBACK_CP, 1'b1);
                    pos++;
                end
                n++;
            end
            held_cnt = 2'd0;
            need_cnt = 2'd0;
        end else if (held_cnt == 2'd0) begin
            k = 32'(follower_need(it.data_byte));
            if (!it.data_byte[7]) begin
                fresh[0] = make_result({13'd0, it.data_byte}, 1'b0);
                n = 1;
            end else if (k != 0) begin
                held[0]  = it.data_byte;
                held_cnt = 2'd1;
                need_cnt = k[1:0];
            end else begin
                fresh[0] = make_result(FALLBACK_CP, 1'b1);
                n = 1;
            end
        end else if (held_cnt >= need_cnt || held_cnt == 2'd3) begin
            k = (need_cnt == 2'd0) ? 32'd1 : 32'(need_cnt);
            for (int unsigned i = 0; i < k; i++)
                seq[i] = held[i];
            seq[k]   = it.data_byte;
            fresh[0] = make_result(join_code(seq, 0, k), 1'b0);
            n        = 1;
            held_cnt = 2'd0;
            need_cnt = 2'd0;
        end else begin
            held[held_cnt] = it.data_byte;
            held_cnt       = held_cnt + 2'd1;
        end

        if (n > 0) begin
            fresh[n-1].run_last = 1'b1;
            fresh[n-1].text_end = it.text_last;
        end
        for (int unsigned i = 0; i < n; i++)
            code_points_due.push_back(fresh[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (code_points_due.size() == 0) begin
            report_mismatch("result with nothing expected, code point",
                            {11'd0, got.code_point}, 32'd0);
            return;
        end
        want = code_points_due.pop_front();
        if (got.code_point !== want.code_point)
            report_mismatch("code_point", {11'd0, got.code_point}, {11'd0, want.code_point});
        if (got.substituted !== want.substituted)
            report_mismatch("substituted", {31'd0, got.substituted}, {31'd0, want.substituted});
        if (got.run_last !== want.run_last)
            report_mismatch("run_last", {31'd0, got.run_last}, {31'd0, want.run_last});
        if (got.text_end !== want.text_end)
            report_mismatch("text_end", {31'd0, got.text_end}, {31'd0, want.text_end});
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_cnt = 2'd0;
            need_cnt = 2'd0;
            code_points_due.delete();
        end else begin
            if (s_valid && s_ready)
                decode_byte(s_item);
            if (m_valid && m_ready)
                check_result(m_item);
        end
        results_due <= code_points_due.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_utf8_lenient_decoder.sv =====
`default_nettype none

module tb_utf8_lenient_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8ld_pkg::*;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;

    int unsigned mismatches;
    int unsigned results_due;

    // Raised once the directed text has been fully decoded; the receiver uses it
    // to place its long hold-off inside the random traffic.
    bit          bulk_phase = 1'b0;

    // Every byte of the text, in the order in which it is offered.
    in_item_t    text_bytes[$];

    utf8_lenient_decoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    utf8_decode_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void add_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        it.data_byte = b;
        it.text_last = last;
        text_bytes.push_back(it);
    endfunction

    // In the random text any byte may close the text now and then, which breaks
    // sequences at every position; force_last closes it on purpose.
    function automatic void emit(input logic [7:0] b, input logic force_last);
        add_byte(b, force_last || ($urandom_range(0, 11) == 0));
    endfunction

    // Sender: the text goes out in bursts of random length with idle gaps in
    // between. Twice it stops and waits until every expected code point has
    // been delivered, once after the directed text and once in the middle of
    // the random text.
    initial begin : text_source
        int unsigned idx;
        int unsigned burst_left;
        int unsigned pause_a;
        int unsigned pause_b;
        int unsigned kind;
        int unsigned n;
        int unsigned m;
        logic [7:0]  r;
        logic [7:0]  lead;

        // Directed text. Plain bytes at both ends of the ASCII range and a
        // literal question mark, which must not be flagged as substituted.
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h3F, 1'b0);
        // Bytes that cannot start a sequence: a stray continuation byte and
        // the bytes above any lead.
        add_byte(8'h80, 1'b0);
        add_byte(8'hF8, 1'b0);
        add_byte(8'hFF, 1'b0);
        // Complete sequences of two, three and four bytes, the last one
        // giving the largest code point the block can form.
        add_byte(8'hC3, 1'b0);
        add_byte(8'hA9, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hAC, 1'b0);
        add_byte(8'hF7, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        // A following byte whose continuation bits are wrong is still used.
        add_byte(8'hC0, 1'b0);
        add_byte(8'h29, 1'b0);
        // A lead alone at the end of the text.
        add_byte(8'hF0, 1'b1);
        // A text that ends inside a sequence: the lead becomes a fallback and
        // the plain byte after it is decoded again.
        add_byte(8'hE2, 1'b0);
        add_byte(8'h41, 1'b1);
        // Three leads at the end give three fallbacks from one byte.
        add_byte(8'hF0, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'hF0, 1'b1);
        // A truncated four-byte lead hiding a complete two-byte sequence.
        add_byte(8'hF0, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'hA9, 1'b1);

        pause_a = text_bytes.size();
        pause_b = pause_a + 190;

        // Random text: mostly well-formed characters with random content,
        // the rest invalid bytes, truncated sequences and plain noise.
        while (text_bytes.size() < 380) begin
            kind = $urandom_range(0, 9);
            n    = $urandom_range(1, 3);
            r    = 8'($urandom);
            case (n)
                1: begin
                    lead = {3'b110, r[4:0]};
                end
                2: begin
                    lead = {4'b1110, r[3:0]};
                end
                default: begin
                    lead = {5'b11110, r[2:0]};
                end
            endcase
            if (kind < 3) begin
                emit({1'b0, r[6:0]}, 1'b0);
            end else if (kind < 7) begin
                emit(lead, 1'b0);
                for (int unsigned i = 0; i < n; i++) begin
                    r = 8'($urandom);
                    if ($urandom_range(0, 7) == 0)
                        emit(r, 1'b0);
                    else
                        emit({2'b10, r[5:0]}, 1'b0);
                end
            end else if (kind == 7) begin
                if (r[7])
                    emit({5'b11111, r[2:0]}, 1'b0);
                else
                    emit({2'b10, r[5:0]}, 1'b0);
            end else if (kind == 8) begin
                m = $urandom_range(0, n - 1);
                emit(lead, m == 0);
                for (int unsigned i = 1; i <= m; i++) begin
                    r = 8'($urandom);
                    emit({2'b10, r[5:0]}, i == m);
                end
            end else begin
                emit(r, 1'b0);
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        idx        = 0;
        burst_left = $urandom_range(1, 40);
        while (idx < text_bytes.size()) begin
            if (idx == pause_a || idx == pause_b) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (results_due != 0);
                bulk_phase = 1'b1;
            end
            s_item  <= text_bytes[idx];
            s_valid <= 1'b1;
            do @(posedge aclk); while (!s_ready);
            idx++;
            burst_left--;
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                burst_left = $urandom_range(1, 40);
            end
        end
        s_valid <= 1'b0;

        // Let every expected code point arrive, then allow a few more cycles so
        // that any surplus transfer from the block is caught.
        do @(posedge aclk); while (results_due != 0);
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && results_due == 0)
            $display("tb_utf8_lenient_decoder: clean");
        else
            $display("tb_utf8_lenient_decoder: errors");
        $finish;
    end

    // Receiver: ready follows a pattern that changes from segment to segment,
    // from always ready to mostly stalled. Once the random text is under way it
    // holds off for a long stretch so that the block fills and stalls its input.
    initial begin : result_sink
        int unsigned seg_len;
        int unsigned style;
        bit          hold_done;
        hold_done = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (bulk_phase && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (150) @(posedge aclk);
            end
            style   = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 80);
            repeat (seg_len) begin
                case (style)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        m_ready <= ($urandom_range(0, 1) != 0);
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 5) == 0);
                    end
                endcase
                @(posedge aclk);
            end
        end
    end

    // Safety net: a correct run needs well under a tenth of this time.
    initial begin : watchdog
        #2ms;
        $display("tb_utf8_lenient_decoder: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/utf8ld_pkg.sv
src/utf8ld_decode.sv
src/utf8ld_out_buf.sv
src/utf8_lenient_decoder.sv
tb/sv/utf8_decode_checker.sv
tb/sv/tb_utf8_lenient_decoder.sv
